FILE: rtl/core/nmof_pkg.sv
// ----------------------------------------------------------------------------
// nmof_pkg: shared types and constants
// Sizes, register codes and pipeline records of the neighbour mean
// outlier filter.
// ----------------------------------------------------------------------------
package nmof_pkg;

  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PIXEL_BITS    = 24;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_BITS    = 10;
  localparam int HEIGHT_BITS   = 13;
  localparam int LIMIT_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int COUNT_BITS    = 32;
  localparam int SUM_BITS      = PIXEL_BITS + 3;
  localparam int PROD_BITS     = SUM_BITS + LIMIT_BITS + 1;
  // centre * 8 neighbours * 256 (Q8.8 limit)
  localparam int RATIO_SHIFT   = 11;
  localparam int MEAN_SHIFT    = 3;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 10'd512;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd512;
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 16'd512;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_PLANE_HEIGHT = 2'd1,
    CFG_RATIO_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  // raster info of one item, taken at the input transfer
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic                interior;
    logic                last;
    logic                upper_ok;
    logic                middle_ok;
  } pos_t;

  typedef struct packed {
    logic                  out_valid;
    pixel_t                value;
    logic                  replaced;
    logic                  last;
    logic [COUNT_BITS-1:0] total;
  } res_t;

endpackage

FILE: rtl/core/neighbour_mean_outlier_filter.sv
// ----------------------------------------------------------------------------
// neighbour_mean_outlier_filter: streaming 3x3 eight-neighbour outlier filter
// Line stores, raster tracking and window logic around an input stage and
// a result register.
// ----------------------------------------------------------------------------
// Flow: an item enters the input stage register at its input transfer, where the
//   row stores are read, and is loaded into the output register when the stage moves.
// Throughput: one item per clock unless res_ready_i stalls a full result register;
//   the sum, one 17x27 multiply and the compare lie between stage and result register.
// Reset: clears positions, window, count and handshake state; store contents
//   are masked by the row fill state, so no clearing pass is run.
module neighbour_mean_outlier_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  nmof_pkg::pixel_t                   pixel_value_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic                               out_valid_o,
  output nmof_pkg::pixel_t                   out_value_o,
  output logic                               was_replaced_o,
  output logic                               plane_last_o,
  output logic [nmof_pkg::COUNT_BITS-1:0]    replaced_total_o,
  input  logic                               cfg_we_i,
  input  logic [nmof_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [nmof_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import nmof_pkg::*;

  // configuration
  logic [WIDTH_BITS-1:0]  line_width_q, eff_width;
  logic [HEIGHT_BITS-1:0] plane_height_q, eff_height;
  logic [LIMIT_BITS-1:0]  ratio_limit_q;
  logic                   cfg_hit;

  // handshake
  logic in_xfer, a_step;

  // input stage
  logic   a_valid_q, a_pix_q;
  pixel_t a_value_q;
  pos_t   a_pos_q;
  logic   a_fwd_q, a_fwd_mark_q;
  pixel_t a_fwd_up_q, a_fwd_mid_q;
  pos_t   pos;
  logic   fwd;

  // row stores
  pixel_t                up_rdata;
  logic [PIXEL_BITS:0]   mid_rdata;
  pixel_t                up_eff, mid_eff;
  logic                  mark_eff;

  // result register
  logic b_valid_q;
  res_t b_res_q, res;

  always_comb begin
    case (cfg_index_i)
      CFG_LINE_WIDTH, CFG_PLANE_HEIGHT, CFG_RATIO_LIMIT: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase

    if (line_width_q == '0) begin
      eff_width = WIDTH_BITS'(1);
    end else if (line_width_q > WIDTH_BITS'(MAX_WIDTH)) begin
      eff_width = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      eff_width = line_width_q;
    end

    if (plane_height_q == '0) begin
      eff_height = HEIGHT_BITS'(1);
    end else if (plane_height_q > HEIGHT_BITS'(MAX_HEIGHT)) begin
      eff_height = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      eff_height = plane_height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= WIDTH_RESET;
      plane_height_q <= HEIGHT_RESET;
      ratio_limit_q  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i[WIDTH_BITS-1:0];
        CFG_PLANE_HEIGHT: plane_height_q <= cfg_wdata_i[HEIGHT_BITS-1:0];
        CFG_RATIO_LIMIT:  ratio_limit_q  <= cfg_wdata_i[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign a_step     = a_valid_q && (!b_valid_q || res_ready_i);
  assign in_ready_o = !a_valid_q || a_step;
  assign in_xfer    = in_valid_i && in_ready_o;

  nmof_raster u_raster (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_hit),
    .adv_i    (in_xfer),
    .width_i  (eff_width),
    .height_i (eff_height),
    .pos_o    (pos)
  );

  // with a one-pixel line, or after a config write restarts at column 0, the next item can hit the column being written
  assign fwd = a_step && (a_pos_q.col == pos.col);

  nmof_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (a_step),
    .waddr_i (a_pos_q.col),
    .wdata_i (mid_eff),
    .re_i    (in_xfer),
    .raddr_i (pos.col),
    .rdata_o (up_rdata)
  );

  nmof_ram #(
    .WIDTH (PIXEL_BITS + 1),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (a_step),
    .waddr_i (a_pos_q.col),
    .wdata_i ({a_pix_q, a_value_q}),
    .re_i    (in_xfer),
    .raddr_i (pos.col),
    .rdata_o (mid_rdata)
  );

  always_comb begin
    up_eff   = '0;
    mid_eff  = '0;
    mark_eff = 1'b0;
    if (a_pos_q.upper_ok) begin
      up_eff = a_fwd_q ? a_fwd_up_q : up_rdata;
    end
    if (a_pos_q.middle_ok) begin
      mid_eff  = a_fwd_q ? a_fwd_mid_q : mid_rdata[PIXEL_BITS-1:0];
      mark_eff = a_fwd_q ? a_fwd_mark_q : mid_rdata[PIXEL_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_fwd_q   <= 1'b0;
    end else begin
      if (in_xfer) begin
        a_valid_q <= 1'b1;
        a_fwd_q   <= fwd;
      end else if (a_step) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_pix_q      <= (command_i == CMD_PIXEL);
      a_value_q    <= (command_i == CMD_PIXEL) ? pixel_value_i : '0;
      a_pos_q      <= pos;
      a_fwd_up_q   <= mid_eff;
      a_fwd_mid_q  <= a_value_q;
      a_fwd_mark_q <= a_pix_q;
    end
  end

  nmof_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_hit),
    .step_i     (a_step),
    .value_i    (a_value_q),
    .up_i       (up_eff),
    .mid_i      (mid_eff),
    .mark_i     (mark_eff),
    .interior_i (a_pos_q.interior),
    .last_i     (a_pos_q.last),
    .limit_i    (ratio_limit_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_step) begin
      b_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_step) begin
      b_res_q <= res;
    end
  end

  assign res_valid_o      = b_valid_q;
  assign out_valid_o      = b_res_q.out_valid;
  assign out_value_o      = b_res_q.value;
  assign was_replaced_o   = b_res_q.replaced;
  assign plane_last_o     = b_res_q.last;
  assign replaced_total_o = b_res_q.total;

  a_stage_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> in_ready_o) else $error("empty input stage not ready");

  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_step |=> b_valid_q) else $error("stage transfer lost");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_step |=> a_valid_q && $stable(a_pos_q))
    else $error("stalled item dropped or changed");

  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_res_q.out_valid |-> b_res_q.total == '0 && !b_res_q.replaced)
    else $error("empty result slot carries data");

endmodule

FILE: rtl/core/nmof_ram.sv
// ----------------------------------------------------------------------------
// nmof_ram: generic dual-port RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module nmof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/nmof_raster.sv
// ----------------------------------------------------------------------------
// nmof_raster: raster position tracking
// Column/row of the incoming item, window centre border flags and
// row-store fill state.
// ----------------------------------------------------------------------------
module nmof_raster (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             adv_i,
  input  logic [nmof_pkg::WIDTH_BITS-1:0]  width_i,
  input  logic [nmof_pkg::HEIGHT_BITS-1:0] height_i,
  output nmof_pkg::pos_t                   pos_o
);
  import nmof_pkg::*;

  localparam logic [1:0] SEEN_BOTH = 2'd2;

  logic [COL_BITS-1:0]    col_q, col_d;
  logic [ROW_BITS-1:0]    row_q, row_d;
  logic [1:0]             seen_q, seen_d;
  logic [WIDTH_BITS-1:0]  col_w, pc;
  logic [HEIGHT_BITS-1:0] row_h, pr, row_bump;
  logic                   borrow, col_end, row_end;

  always_comb begin
    col_w    = WIDTH_BITS'(col_q);
    row_h    = HEIGHT_BITS'(row_q);
    borrow   = (col_q == '0);
    row_bump = HEIGHT_BITS'(borrow);
    col_end  = (col_w == width_i - 1'b1);
    row_end  = (row_h == height_i - 1'b1);

    // centre sits one row and one column behind the incoming item
    pc = borrow ? width_i - 1'b1 : col_w - 1'b1;
    if (height_i == HEIGHT_BITS'(1)) begin
      pr = '0;
    end else if (row_h < row_bump + HEIGHT_BITS'(1)) begin
      pr = row_h + height_i - HEIGHT_BITS'(1) - row_bump;
    end else begin
      pr = row_h - HEIGHT_BITS'(1) - row_bump;
    end

    pos_o.col       = col_q;
    pos_o.interior  = (pc != '0) && (pc < width_i - 1'b1) &&
                      (pr != '0) && (pr < height_i - 1'b1);
    pos_o.last      = (pc == width_i - 1'b1) && (pr == height_i - 1'b1);
    // middle store entry holds data once a full row went through, upper entry once two did
    pos_o.middle_ok = (seen_q != '0);
    pos_o.upper_ok  = (seen_q == SEEN_BOTH);

    col_d  = col_q;
    row_d  = row_q;
    seen_d = seen_q;
    if (clear_i) begin
      col_d  = '0;
      row_d  = '0;
      seen_d = '0;
    end else if (adv_i) begin
      if (col_end) begin
        col_d  = '0;
        row_d  = row_end ? '0 : row_q + 1'b1;
        seen_d = (seen_q == SEEN_BOTH) ? seen_q : seen_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      seen_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      seen_q <= seen_d;
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_w < width_i) else $error("column position beyond line width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_h < height_i) else $error("row position beyond plane height");

  a_seen_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3) else $error("row fill state out of range");

  a_seen_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(seen_q) |-> col_q == '0) else $error("fill state moved mid-row");

endmodule

FILE: rtl/core/nmof_window.sv
// ----------------------------------------------------------------------------
// nmof_window: 3x3 window and outlier decision
// Holds the two older window columns, sums the eight neighbours, runs the
// ratio test and keeps the saturating replacement count.
// ----------------------------------------------------------------------------
module nmof_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  logic                            step_i,
  input  nmof_pkg::pixel_t                value_i,
  input  nmof_pkg::pixel_t                up_i,
  input  nmof_pkg::pixel_t                mid_i,
  input  logic                            mark_i,
  input  logic                            interior_i,
  input  logic                            last_i,
  input  logic [nmof_pkg::LIMIT_BITS-1:0] limit_i,
  output nmof_pkg::res_t                  res_o
);
  import nmof_pkg::*;

  pixel_t                 c1_q [3];
  pixel_t                 c2_q [3];
  logic                   mark_q;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [PROD_BITS-1:0] prod, lhs;
  logic                   replaced, bump;
  pixel_t                 centre, mean;

  always_comb begin
    centre = c2_q[1];
    sum = SUM_BITS'(c1_q[0]) + SUM_BITS'(c2_q[0]) + SUM_BITS'(up_i)
        + SUM_BITS'(c1_q[1]) + SUM_BITS'(mid_i)
        + SUM_BITS'(c1_q[2]) + SUM_BITS'(c2_q[2]) + SUM_BITS'(value_i);
    prod = PROD_BITS'($signed({1'b0, limit_i})) * PROD_BITS'(sum);
    lhs  = $signed({(PROD_BITS-RATIO_SHIFT)'(centre), RATIO_SHIFT'(0)});
    replaced = interior_i && (lhs > prod);
    // arithmetic shift gives the floor of the mean
    mean = PIXEL_BITS'(sum >>> MEAN_SHIFT);

    bump    = mark_q && replaced && (count_q != '1);
    count_d = count_q + COUNT_BITS'(bump);

    res_o.out_valid = mark_q;
    res_o.value     = mark_q ? (replaced ? mean : centre) : '0;
    res_o.replaced  = mark_q && replaced;
    res_o.last      = mark_q && last_i;
    res_o.total     = mark_q ? count_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        c1_q[i] <= '0;
        c2_q[i] <= '0;
      end
      mark_q  <= 1'b0;
      count_q <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < 3; i++) begin
        c1_q[i] <= '0;
        c2_q[i] <= '0;
      end
      mark_q  <= 1'b0;
      count_q <= '0;
    end else if (step_i) begin
      for (int i = 0; i < 3; i++) begin
        c1_q[i] <= c2_q[i];
      end
      c2_q[0] <= up_i;
      c2_q[1] <= mid_i;
      c2_q[2] <= value_i;
      mark_q  <= mark_i;
      count_q <= count_d;
    end
  end

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i && !clear_i |=> $stable(count_q)) else $error("count moved without a step");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_i |=> count_q >= $past(count_q)) else $error("count went down");

  a_repl_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.replaced |-> res_o.out_valid && interior_i)
    else $error("replacement on a border or empty slot");

endmodule
